[src/address_bloom_filter_unit_defines.svh]
// Assertion macros shared by the address Bloom filter RTL.
`ifndef ADDRESS_BLOOM_FILTER_UNIT_DEFINES_SVH
`define ADDRESS_BLOOM_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define ABF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define ABF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ABF_ASSERT_NOW(label, ante, cons, msg)
`define ABF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[src/abf_pkg.sv]
// Types, constants and helper functions of the address Bloom filter.
`default_nettype none
package abf_pkg;

   // Filter geometry; both sizes are powers of two.
   localparam int FILTER_BITS_LOG2  = 10;
   localparam int FILTER_BITS       = 1 << FILTER_BITS_LOG2;
   localparam int FILTER_WORDS_LOG2 = 4;
   localparam int FILTER_WORDS      = 1 << FILTER_WORDS_LOG2;
   localparam int WSEL_W            = FILTER_WORDS_LOG2;
   localparam logic [63:0] FILTER_MASK = 64'(FILTER_BITS - 1);

   // Access length handling.
   localparam int MAX_ACCESS_BYTES = 32;
   localparam int CNT_W            = $clog2(MAX_ACCESS_BYTES + 1);

   // Hash seeds and round rotations.
   localparam int POINTER_BYTES = 8;
   localparam logic [63:0] MIX_CONST  = 64'hdeadbeefdeadbeef;
   localparam logic [63:0] MIX_D_INIT = MIX_CONST + (64'(POINTER_BYTES) << 56);
   localparam int MIX_ROUNDS = 11;
   localparam int ROUND_W    = $clog2(MIX_ROUNDS);
   localparam logic [5:0] MIX_ROT [MIX_ROUNDS] = '{
      6'd15, 6'd52, 6'd26, 6'd51, 6'd28, 6'd9, 6'd47, 6'd54, 6'd32, 6'd25, 6'd63
   };

   // Queue depths between and after the two halves.
   localparam int WQ_DEPTH = 2;
   localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
   localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);
   localparam int OQ_DEPTH = 2;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ADD       = 2'd0,
      CMD_LOAD      = 2'd1,
      CMD_INTERSECT = 2'd2,
      CMD_CLEAR     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_REPORT
   } back_state_type;

   // Input item as it arrives on the request side.
   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] address;
      logic [5:0]  access_length;
      logic [3:0]  word_index;
      logic [63:0] word_value;
   } req_type;

   // Result item.
   typedef struct packed {
      logic overlap_found;
      logic filter_empty;
   } rsp_type;

   // Classified work item held between front and back.
   typedef struct packed {
      cmd_type             command;
      logic [63:0]         address;
      logic [CNT_W-1:0]    length;
      logic [WSEL_W-1:0]   word_sel;
      logic                word_ok;
      logic [63:0]         word_value;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type item;
   } work_port_type;

   typedef struct packed {
      logic        start;
      logic [63:0] address;
   } hash_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } hash_rsp_type;

   // Rotate left by a 6-bit amount.
   function automatic logic [63:0] rotl64(logic [63:0] x, logic [5:0] k);
      logic [127:0] dbl;
      dbl = {x, x} << k;
      return dbl[127:64];
   endfunction

endpackage
`default_nettype wire

[src/abf_front.sv]
// Front half: classifies request items and queues them for the back half.
`default_nettype none
`include "address_bloom_filter_unit_defines.svh"
module abf_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire abf_pkg::req_type      req_data,
   output abf_pkg::work_port_type     work_out,
   input  wire logic                  work_pop
);

   localparam int CntW  = abf_pkg::CNT_W;
   localparam int WselW = abf_pkg::WSEL_W;
   localparam int PtrW  = abf_pkg::WQ_PTR_W;
   localparam int CntQW = abf_pkg::WQ_CNT_W;

   abf_pkg::work_type fq_ff [abf_pkg::WQ_DEPTH];
   abf_pkg::work_type entry_in;
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntQW-1:0]  count_ff, count_in;
   logic              accept;
   logic              release_head;

   // Classify the incoming item: saturate the length, check the word index.
   always_comb begin
      entry_in.command    = abf_pkg::cmd_type'(req_data.command);
      entry_in.address    = req_data.address;
      entry_in.length     = (32'(req_data.access_length) > abf_pkg::MAX_ACCESS_BYTES)
                            ? CntW'(abf_pkg::MAX_ACCESS_BYTES)
                            : CntW'(req_data.access_length);
      entry_in.word_sel   = WselW'(req_data.word_index);
      entry_in.word_ok    = 32'(req_data.word_index) < abf_pkg::FILTER_WORDS;
      entry_in.word_value = req_data.word_value;
   end

   // Queue handshakes.
   assign full         = (count_ff == CntQW'(abf_pkg::WQ_DEPTH));
   assign accept       = push && !full;
   assign release_head = work_pop && (count_ff != '0);

   assign work_out.valid = (count_ff != '0);
   assign work_out.item  = fq_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(abf_pkg::WQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (release_head) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(abf_pkg::WQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (accept && !release_head) begin
         count_in = count_ff + CntQW'(1);
      end else if (!accept && release_head) begin
         count_in = count_ff - CntQW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         fq_ff[wr_ptr_ff] <= entry_in;
      end
   end

   // The back half only removes an item that is present.
   `ABF_ASSERT_NOW(a_pop_nonempty, work_pop, count_ff != '0, "work queue popped while empty")

endmodule
`default_nettype wire

[src/abf_hash.sv]
// Iterative hash unit: one mixing round of the short finalizer per cycle.
`default_nettype none
`include "address_bloom_filter_unit_defines.svh"
module abf_hash (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire abf_pkg::hash_req_type hash_req,
   output abf_pkg::hash_rsp_type      hash_rsp
);

   localparam int RoundW = abf_pkg::ROUND_W;

   logic [63:0]       a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [RoundW-1:0] round_ff, round_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [63:0]       src;
   logic [63:0]       dst;
   logic [63:0]       src_rot;
   logic [63:0]       dst_mix;
   logic              last_round;

   assign last_round = (round_ff == RoundW'(abf_pkg::MIX_ROUNDS - 1));

   // Pick the word pair of this round: the roles move d<-c, a<-d, b<-a, c<-b.
   always_comb begin
      unique case (round_ff[1:0])
         2'd0: begin
            src = c_ff;
            dst = d_ff;
         end
         2'd1: begin
            src = d_ff;
            dst = a_ff;
         end
         2'd2: begin
            src = a_ff;
            dst = b_ff;
         end
         default: begin
            src = b_ff;
            dst = c_ff;
         end
      endcase
      src_rot = abf_pkg::rotl64(src, abf_pkg::MIX_ROT[round_ff]);
      dst_mix = (dst ^ src) + src_rot;
   end

   // Next values of the hash state.
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = busy_ff && last_round;
      if (hash_req.start) begin
         a_in     = '0;
         b_in     = '0;
         c_in     = abf_pkg::MIX_CONST + hash_req.address;
         d_in     = abf_pkg::MIX_D_INIT;
         round_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         unique case (round_ff[1:0])
            2'd0: begin
               c_in = src_rot;
               d_in = dst_mix;
            end
            2'd1: begin
               d_in = src_rot;
               a_in = dst_mix;
            end
            2'd2: begin
               a_in = src_rot;
               b_in = dst_mix;
            end
            default: begin
               b_in = src_rot;
               c_in = dst_mix;
            end
         endcase
         round_in = round_ff + RoundW'(1);
         if (last_round) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         round_ff <= round_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

   assign hash_rsp.done  = done_ff;
   assign hash_rsp.value = a_ff;

   // A new hash never starts while one is running, and a start runs rounds.
   `ABF_ASSERT_NOW(a_start_idle, hash_req.start, !busy_ff, "hash started while busy")
   `ABF_ASSERT_NEXT(a_start_busy, hash_req.start, busy_ff && !done_ff, "hash start not taken")

endmodule
`default_nettype wire

[src/abf_back.sv]
// Back half: executes work items on the filter words and queues the results.
`default_nettype none
`include "address_bloom_filter_unit_defines.svh"
module abf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire abf_pkg::work_port_type work_in,
   output logic                        work_pop,
   output abf_pkg::hash_req_type       hash_req,
   input  wire abf_pkg::hash_rsp_type  hash_rsp,
   output logic                        empty,
   input  wire logic                   pop,
   output abf_pkg::rsp_type            rsp_data
);

   localparam int CntW  = abf_pkg::CNT_W;
   localparam int WselW = abf_pkg::WSEL_W;
   localparam int PtrW  = abf_pkg::OQ_PTR_W;
   localparam int CntQW = abf_pkg::OQ_CNT_W;

   abf_pkg::back_state_type state_ff, state_in;
   logic [CntW-1:0]   remain_ff, remain_in;
   logic [63:0]       addr_ff, addr_in;
   logic              sticky_ff, sticky_in;
   logic [63:0]       filter_ff [abf_pkg::FILTER_WORDS];
   logic [abf_pkg::FILTER_WORDS-1:0] nz_ff;
   logic [63:0]       filter_word_in;
   logic [WselW-1:0]  wr_sel;
   logic [WselW-1:0]  rd_sel;
   logic [63:0]       rd_word;
   logic              wr_en;
   logic              clear_all;
   logic              sticky_en;
   logic              take;
   logic              result_push;
   logic [63:0]       bit_num;
   logic [WselW-1:0]  hash_word;
   logic [63:0]       hash_bit;
   logic              hit;

   abf_pkg::rsp_type  oq_ff [abf_pkg::OQ_DEPTH];
   abf_pkg::rsp_type  result_in;
   logic [PtrW-1:0]   oq_wr_ptr_ff, oq_wr_ptr_in;
   logic [PtrW-1:0]   oq_rd_ptr_ff, oq_rd_ptr_in;
   logic [CntQW-1:0]  oq_count_ff, oq_count_in;
   logic              oq_room;
   logic              oq_release;

   // Bit position of a finished hash inside the filter.
   assign bit_num   = hash_rsp.value & abf_pkg::FILTER_MASK;
   assign hash_word = bit_num[6 +: WselW];
   assign hash_bit  = 64'd1 << bit_num[5:0];

   // One read port over the filter words.
   assign rd_sel  = (state_ff == abf_pkg::ST_HASH) ? hash_word : work_in.item.word_sel;
   assign rd_word = filter_ff[rd_sel];
   assign hit     = (rd_word & work_in.item.word_value) != '0;

   assign oq_room = (oq_count_ff != CntQW'(abf_pkg::OQ_DEPTH));
   assign take    = work_in.valid && oq_room;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         abf_pkg::ST_IDLE: begin
            if (take) begin
               if (work_in.item.command == abf_pkg::CMD_ADD && work_in.item.length != '0) begin
                  state_in = abf_pkg::ST_HASH;
               end else begin
                  state_in = abf_pkg::ST_REPORT;
               end
            end
         end
         abf_pkg::ST_HASH: begin
            if (hash_rsp.done && remain_ff == CntW'(1)) begin
               state_in = abf_pkg::ST_REPORT;
            end
         end
         abf_pkg::ST_REPORT: begin
            state_in = abf_pkg::ST_IDLE;
         end
         default: begin
            state_in = abf_pkg::ST_IDLE;
         end
      endcase
   end

   // Control strobes and datapath next values.
   always_comb begin
      work_pop         = 1'b0;
      hash_req.start   = 1'b0;
      hash_req.address = addr_ff;
      wr_en            = 1'b0;
      wr_sel           = work_in.item.word_sel;
      filter_word_in   = work_in.item.word_value;
      clear_all        = 1'b0;
      sticky_en        = 1'b0;
      result_push      = 1'b0;
      remain_in        = remain_ff;
      addr_in          = addr_ff;
      unique case (state_ff)
         abf_pkg::ST_IDLE: begin
            work_pop = take;
            if (take) begin
               unique case (work_in.item.command)
                  abf_pkg::CMD_ADD: begin
                     if (work_in.item.length != '0) begin
                        hash_req.start   = 1'b1;
                        hash_req.address = work_in.item.address;
                        addr_in          = work_in.item.address + 64'd1;
                        remain_in        = work_in.item.length;
                     end
                  end
                  abf_pkg::CMD_LOAD: begin
                     wr_en = work_in.item.word_ok;
                  end
                  abf_pkg::CMD_INTERSECT: begin
                     sticky_en = work_in.item.word_ok;
                  end
                  default: begin
                     clear_all = 1'b1;
                  end
               endcase
            end
         end
         abf_pkg::ST_HASH: begin
            if (hash_rsp.done) begin
               wr_en          = 1'b1;
               wr_sel         = hash_word;
               filter_word_in = rd_word | hash_bit;
               remain_in      = remain_ff - CntW'(1);
               if (remain_ff != CntW'(1)) begin
                  hash_req.start = 1'b1;
                  addr_in        = addr_ff + 64'd1;
               end
            end
         end
         abf_pkg::ST_REPORT: begin
            result_push = 1'b1;
         end
         default: begin
            result_push = 1'b0;
         end
      endcase
   end

   // Sticky overlap restarts at word 0.
   always_comb begin
      sticky_in = sticky_ff;
      if (sticky_en) begin
         sticky_in = (work_in.item.word_sel == '0) ? hit : (sticky_ff || hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= abf_pkg::ST_IDLE;
         sticky_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sticky_ff <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      addr_ff   <= addr_in;
   end

   // Filter words with a nonzero flag per word for the emptiness report.
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < abf_pkg::FILTER_WORDS; i++) begin
            filter_ff[i] <= '0;
         end
         nz_ff <= '0;
      end else if (wr_en) begin
         filter_ff[wr_sel] <= filter_word_in;
         nz_ff[wr_sel]     <= (filter_word_in != '0);
      end
   end

   // Result queue toward the response side.
   assign result_in.overlap_found = sticky_ff;
   assign result_in.filter_empty  = (nz_ff == '0);
   assign empty      = (oq_count_ff == '0);
   assign oq_release = pop && !empty;
   assign rsp_data   = oq_ff[oq_rd_ptr_ff];

   always_comb begin
      oq_wr_ptr_in = oq_wr_ptr_ff;
      oq_rd_ptr_in = oq_rd_ptr_ff;
      oq_count_in  = oq_count_ff;
      if (result_push) begin
         oq_wr_ptr_in = (oq_wr_ptr_ff == PtrW'(abf_pkg::OQ_DEPTH - 1))
                        ? '0 : oq_wr_ptr_ff + PtrW'(1);
      end
      if (oq_release) begin
         oq_rd_ptr_in = (oq_rd_ptr_ff == PtrW'(abf_pkg::OQ_DEPTH - 1))
                        ? '0 : oq_rd_ptr_ff + PtrW'(1);
      end
      if (result_push && !oq_release) begin
         oq_count_in = oq_count_ff + CntQW'(1);
      end else if (!result_push && oq_release) begin
         oq_count_in = oq_count_ff - CntQW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ptr_ff <= '0;
         oq_rd_ptr_ff <= '0;
         oq_count_ff  <= '0;
      end else begin
         oq_wr_ptr_ff <= oq_wr_ptr_in;
         oq_rd_ptr_ff <= oq_rd_ptr_in;
         oq_count_ff  <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_push) begin
         oq_ff[oq_wr_ptr_ff] <= result_in;
      end
   end

   // The result slot reserved at item start is still free when reporting.
   `ABF_ASSERT_NOW(a_report_room, state_ff == abf_pkg::ST_REPORT, oq_room, "no room for result")
   // Hash completions only arrive while an add is in progress.
   `ABF_ASSERT_NOW(a_done_in_hash, hash_rsp.done, state_ff == abf_pkg::ST_HASH, "stray hash done")

endmodule
`default_nettype wire

[src/address_bloom_filter_unit.sv]
// Top level of the address Bloom filter: front queue, hash unit and back end.
`default_nettype none
// The unit keeps a 1024-bit Bloom filter in 16 words of 64 bits and takes
// commands through a queue-style request port (push/full) and returns exactly
// one result per command through a queue-style response port (empty/pop).
// Up to two classified commands wait in front of the execution stage and up to
// two results wait for the consumer. Commands execute one at a time. An add of
// n bytes (n saturated to 32) runs every byte address through the eleven-round
// hash unit, which does one round per cycle. The filter is all zero and the
// overlap flag clear after reset, with no initialization pass.
module address_bloom_filter_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire abf_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output abf_pkg::rsp_type      rsp_data
);

   abf_pkg::work_port_type work;
   logic                   work_pop;
   abf_pkg::hash_req_type  hash_req;
   abf_pkg::hash_rsp_type  hash_rsp;

   // Request classification and queue.
   abf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .work_out (work),
      .work_pop (work_pop)
   );

   // Shared hash unit.
   abf_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .hash_req (hash_req),
      .hash_rsp (hash_rsp)
   );

   // Execution and result queue.
   abf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .work_in  (work),
      .work_pop (work_pop),
      .hash_req (hash_req),
      .hash_rsp (hash_rsp),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
